[hw/rtl/axis_finite_difference_stencil_unit_defines.svh]
// Assertion macros for the finite difference stencil unit.
`ifndef AXIS_FINITE_DIFFERENCE_STENCIL_UNIT_DEFINES_SVH
`define AXIS_FINITE_DIFFERENCE_STENCIL_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define AFDS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);
`define AFDS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define AFDS_ASSERT(lbl, prop, msg)
`define AFDS_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

[hw/rtl/afds_pkg.sv]
package afds_pkg;

  localparam int unsigned MAX_LINE_DEF   = 64;
  localparam int unsigned MAX_PLANE_DEF  = 4096;
  localparam int unsigned MAX_LEVELS_DEF = 1024;
  localparam int unsigned FRAC_BITS_DEF  = 16;

  localparam int unsigned SAMPLE_W = 32;
  localparam int unsigned INDEX_W  = 22;
  localparam int unsigned SCALE_W  = 32;
  localparam int unsigned IXY_W    = 7;
  localparam int unsigned IZ_W     = 11;
  localparam int unsigned HALO_W   = 3;
  localparam int unsigned AXIS_W   = 2;
  localparam int unsigned BF_W     = 2;
  localparam int unsigned PADDR_W  = 5;
  localparam int unsigned PDATA_W  = 32;

  localparam int unsigned EXT_W    = 12;
  localparam int unsigned PLANE_W  = 16;
  localparam int unsigned DIFF_W   = 34;
  localparam int unsigned PP_SPLIT = 17;
  localparam int unsigned PP_W     = PP_SPLIT + SCALE_W;
  localparam int unsigned PROD_W   = DIFF_W + SCALE_W;

  localparam int unsigned OQ_DEPTH = 8;

  localparam logic [HALO_W-1:0] HALO_MAX  = 3'd4;
  localparam logic [IZ_W-1:0]   MIN_INNER = 11'd3;

  localparam logic [AXIS_W-1:0] AXIS_X = 2'd0;
  localparam logic [AXIS_W-1:0] AXIS_Y = 2'd1;
  localparam logic [AXIS_W-1:0] AXIS_Z = 2'd2;

  localparam logic MODE_FWD = 1'b0;
  localparam logic MODE_CTR = 1'b1;

  localparam logic [SAMPLE_W-1:0] SAT_POS = 32'h7FFF_FFFF;
  localparam logic [SAMPLE_W-1:0] SAT_NEG = 32'h8000_0000;

  localparam logic              MODE_RST   = MODE_FWD;
  localparam logic [AXIS_W-1:0] AXIS_RST   = AXIS_X;
  localparam logic [IXY_W-1:0]  INT_XY_RST = 7'd8;
  localparam logic [IZ_W-1:0]   INT_Z_RST  = 11'd8;
  localparam logic [HALO_W-1:0] HALO_RST   = 3'd1;
  localparam logic [SCALE_W-1:0] SCALE_RST = 32'h0001_0000;
  localparam logic [BF_W-1:0]   BF_RST     = 2'd0;

  typedef enum logic [2:0] {
    REG_MODE   = 3'd0,
    REG_AXIS   = 3'd1,
    REG_INT_X  = 3'd2,
    REG_INT_Y  = 3'd3,
    REG_INT_Z  = 3'd4,
    REG_HALO   = 3'd5,
    REG_SCALE  = 3'd6,
    REG_BFLAGS = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic               mode;
    logic               err;
    logic               emit0;
    logic               emit1;
    logic               zero0;
    logic               last0;
    logic [INDEX_W-1:0] idx0;
    logic [INDEX_W-1:0] idx1;
  } ctl_t;

  typedef struct packed {
    logic [INDEX_W-1:0]  idx;
    logic [SAMPLE_W-1:0] value;
    logic                err;
    logic                last;
  } result_t;

endpackage

[hw/rtl/axis_finite_difference_stencil_unit.sv]
// Channel  | Direction | Handshake                  | Payload
// input    | in        | in_valid_i / in_stall_o    | sample_i, first_i
// result   | out       | out_valid_o / out_stall_i  | point_index_o, deriv_value_o,
//          |           |                            | size_error_o, last_of_run_o
// config   | in        | psel, penable, pwrite      | paddr, pwdata, prdata
//
// One transaction per cycle on the input while in_stall_o is low, bounded by the
// two read ports and the write port of the two-plane delay memory. Results pass
// the pipeline and the result queue to out_valid_o; an input that ends a run
// yields up to two results. in_stall_o rises while more than six of the eight
// result queue slots are reserved. Reset restores the register defaults and
// clears counters, pipeline and queue; the delay memory keeps its contents.
`include "axis_finite_difference_stencil_unit_defines.svh"

module axis_finite_difference_stencil_unit #(
  parameter int unsigned MAX_LINE   = afds_pkg::MAX_LINE_DEF,
  parameter int unsigned MAX_PLANE  = afds_pkg::MAX_PLANE_DEF,
  parameter int unsigned MAX_LEVELS = afds_pkg::MAX_LEVELS_DEF,
  parameter int unsigned FRAC_BITS  = afds_pkg::FRAC_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic signed [afds_pkg::SAMPLE_W-1:0] sample_i,
  input  logic                                 first_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [afds_pkg::INDEX_W-1:0]         point_index_o,
  output logic signed [afds_pkg::SAMPLE_W-1:0] deriv_value_o,
  output logic                                 size_error_o,
  output logic                                 last_of_run_o,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [afds_pkg::PADDR_W-1:0]         paddr,
  input  logic [afds_pkg::PDATA_W-1:0]         pwdata,
  output logic [afds_pkg::PDATA_W-1:0]         prdata,
  output logic                                 pready
);

  localparam int unsigned DEPTH  = 2 * MAX_PLANE;
  localparam int unsigned AW     = $clog2(DEPTH);
  localparam int unsigned LINE_W = $clog2(MAX_LINE);
  localparam int unsigned LEV_W  = $clog2(MAX_LEVELS);
  localparam int unsigned OQ_AW  = $clog2(afds_pkg::OQ_DEPTH);
  localparam int unsigned RES_W  = $clog2(afds_pkg::OQ_DEPTH + 1);
  localparam int unsigned EXT_W  = afds_pkg::EXT_W;
  localparam int unsigned IDX_W  = afds_pkg::INDEX_W;
  localparam int unsigned DW     = afds_pkg::DIFF_W;
  localparam int unsigned SW     = afds_pkg::SAMPLE_W;

  // configuration registers
  logic                          mode_q;
  logic [afds_pkg::AXIS_W-1:0]   axis_q;
  logic [afds_pkg::IXY_W-1:0]    interior_x_q;
  logic [afds_pkg::IXY_W-1:0]    interior_y_q;
  logic [afds_pkg::IZ_W-1:0]     interior_z_q;
  logic [afds_pkg::HALO_W-1:0]   halo_q;
  logic [afds_pkg::SCALE_W-1:0]  scale_q;
  logic [afds_pkg::BF_W-1:0]     bflags_q;

  logic                          cfg_we;
  afds_pkg::reg_idx_e            reg_sel;
  logic                          size_clear;

  assign pready     = 1'b1;
  assign cfg_we     = psel & penable & pwrite;
  assign reg_sel    = afds_pkg::reg_idx_e'(paddr[4:2]);
  assign size_clear = cfg_we && (reg_sel != afds_pkg::REG_SCALE) &&
                      (reg_sel != afds_pkg::REG_BFLAGS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= afds_pkg::MODE_RST;
      axis_q       <= afds_pkg::AXIS_RST;
      interior_x_q <= afds_pkg::INT_XY_RST;
      interior_y_q <= afds_pkg::INT_XY_RST;
      interior_z_q <= afds_pkg::INT_Z_RST;
      halo_q       <= afds_pkg::HALO_RST;
      scale_q      <= afds_pkg::SCALE_RST;
      bflags_q     <= afds_pkg::BF_RST;
    end else if (cfg_we) begin
      unique case (reg_sel)
        afds_pkg::REG_MODE:   mode_q       <= pwdata[0];
        afds_pkg::REG_AXIS:   axis_q       <= pwdata[afds_pkg::AXIS_W-1:0];
        afds_pkg::REG_INT_X:  interior_x_q <= pwdata[afds_pkg::IXY_W-1:0];
        afds_pkg::REG_INT_Y:  interior_y_q <= pwdata[afds_pkg::IXY_W-1:0];
        afds_pkg::REG_INT_Z:  interior_z_q <= pwdata[afds_pkg::IZ_W-1:0];
        afds_pkg::REG_HALO:   halo_q       <= pwdata[afds_pkg::HALO_W-1:0];
        afds_pkg::REG_SCALE:  scale_q      <= pwdata[afds_pkg::SCALE_W-1:0];
        afds_pkg::REG_BFLAGS: bflags_q     <= pwdata[afds_pkg::BF_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      afds_pkg::REG_MODE:   prdata = afds_pkg::PDATA_W'(mode_q);
      afds_pkg::REG_AXIS:   prdata = afds_pkg::PDATA_W'(axis_q);
      afds_pkg::REG_INT_X:  prdata = afds_pkg::PDATA_W'(interior_x_q);
      afds_pkg::REG_INT_Y:  prdata = afds_pkg::PDATA_W'(interior_y_q);
      afds_pkg::REG_INT_Z:  prdata = afds_pkg::PDATA_W'(interior_z_q);
      afds_pkg::REG_HALO:   prdata = afds_pkg::PDATA_W'(halo_q);
      afds_pkg::REG_SCALE:  prdata = scale_q;
      afds_pkg::REG_BFLAGS: prdata = afds_pkg::PDATA_W'(bflags_q);
      default:              prdata = '0;
    endcase
  end

  // geometry
  logic [EXT_W-1:0]             nx, ny, nz, halo2;
  logic [afds_pkg::PLANE_W-1:0] plane;
  logic                         geom_err, cfg_err;

  assign halo2 = EXT_W'({halo_q, 1'b0});
  assign nx    = EXT_W'(interior_x_q) + halo2;
  assign ny    = EXT_W'(interior_y_q) + halo2;
  assign nz    = EXT_W'(interior_z_q) + halo2;
  assign plane = afds_pkg::PLANE_W'(nx) * afds_pkg::PLANE_W'(ny);

  assign geom_err = (halo_q > afds_pkg::HALO_MAX) || (interior_x_q == '0) ||
                    (interior_y_q == '0) || (interior_z_q == '0) ||
                    (32'(nx) > 32'(MAX_LINE)) || (32'(ny) > 32'(MAX_LINE)) ||
                    (32'(plane) > 32'(MAX_PLANE)) || (32'(nz) > 32'(MAX_LEVELS));

  // position state
  logic [LINE_W-1:0] pos_x_q, pos_y_q, pos_x_d, pos_y_d, pxe, pye;
  logic [LEV_W-1:0]  pos_z_q, pos_z_d, pze;
  logic [IDX_W-1:0]  idx_q, idx_d, idx_e;
  logic [AW-1:0]     wp_q, wp_d;

  assign pxe   = first_i ? '0 : pos_x_q;
  assign pye   = first_i ? '0 : pos_y_q;
  assign pze   = first_i ? '0 : pos_z_q;
  assign idx_e = first_i ? '0 : idx_q;

  logic [afds_pkg::PLANE_W-1:0] stride;
  logic [EXT_W-1:0]             c, t, hi, pc;
  logic [afds_pkg::IZ_W-1:0]    inner;
  logic                         axis_bad;

  always_comb begin
    stride   = afds_pkg::PLANE_W'(1);
    c        = EXT_W'(pxe);
    t        = nx;
    inner    = afds_pkg::IZ_W'(interior_x_q);
    axis_bad = 1'b0;
    unique case (axis_q)
      afds_pkg::AXIS_X: begin
        stride = afds_pkg::PLANE_W'(1);
        c      = EXT_W'(pxe);
        t      = nx;
        inner  = afds_pkg::IZ_W'(interior_x_q);
      end
      afds_pkg::AXIS_Y: begin
        stride = afds_pkg::PLANE_W'(nx);
        c      = EXT_W'(pye);
        t      = ny;
        inner  = afds_pkg::IZ_W'(interior_y_q);
      end
      afds_pkg::AXIS_Z: begin
        stride = plane;
        c      = EXT_W'(pze);
        t      = nz;
        inner  = interior_z_q;
      end
      default: axis_bad = 1'b1;
    endcase
  end

  assign cfg_err = geom_err || axis_bad ||
                   ((mode_q == afds_pkg::MODE_CTR) && (inner < afds_pkg::MIN_INNER));
  assign hi = t - EXT_W'(1) - EXT_W'(halo_q);
  assign pc = c - EXT_W'(1);

  logic acc, advance;
  assign acc     = in_valid_i && !in_stall_o;
  assign advance = acc && !cfg_err;

  afds_pkg::ctl_t ctl;
  logic [1:0]     n_res;

  always_comb begin
    ctl.mode  = mode_q;
    ctl.err   = cfg_err;
    ctl.emit0 = (c != '0);
    ctl.emit1 = (c == t - EXT_W'(1));
    ctl.last0 = !ctl.emit1;
    ctl.idx0  = idx_e - IDX_W'(stride);
    ctl.idx1  = idx_e;
    if (mode_q == afds_pkg::MODE_FWD) begin
      ctl.zero0 = bflags_q[1] && (pc == hi);
    end else begin
      ctl.zero0 = (pc == '0) || (bflags_q[0] && (pc == EXT_W'(halo_q))) ||
                  (bflags_q[1] && (pc == hi));
    end
    if (cfg_err) begin
      ctl.emit0 = 1'b1;
      ctl.emit1 = 1'b0;
      ctl.zero0 = 1'b1;
      ctl.last0 = 1'b1;
      ctl.idx0  = '0;
    end
    n_res = {1'b0, ctl.emit0} + {1'b0, ctl.emit1};
  end

  logic x_wrap, y_wrap, z_wrap;
  assign x_wrap = (EXT_W'(pxe) + EXT_W'(1)) >= nx;
  assign y_wrap = (EXT_W'(pye) + EXT_W'(1)) >= ny;
  assign z_wrap = (EXT_W'(pze) + EXT_W'(1)) >= nz;

  always_comb begin
    pos_x_d = pxe;
    pos_y_d = pye;
    pos_z_d = pze;
    idx_d   = idx_e;
    wp_d    = wp_q;
    if (advance) begin
      pos_x_d = x_wrap ? '0 : pxe + LINE_W'(1);
      if (x_wrap) begin
        pos_y_d = y_wrap ? '0 : pye + LINE_W'(1);
        if (y_wrap) begin
          pos_z_d = z_wrap ? '0 : pze + LEV_W'(1);
        end
      end
      idx_d = (x_wrap && y_wrap && z_wrap) ? '0 : idx_e + IDX_W'(1);
      wp_d  = (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + AW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_x_q <= '0;
      pos_y_q <= '0;
      pos_z_q <= '0;
      idx_q   <= '0;
      wp_q    <= '0;
    end else begin
      if (size_clear) begin
        pos_x_q <= '0;
        pos_y_q <= '0;
        pos_z_q <= '0;
        idx_q   <= '0;
      end else if (acc) begin
        pos_x_q <= pos_x_d;
        pos_y_q <= pos_y_d;
        pos_z_q <= pos_z_d;
        idx_q   <= idx_d;
      end
      wp_q <= wp_d;
    end
  end

  // delay memory: two planes, read one and two strides back
  logic [AW:0] wpx, s1x, s2x, addr_cur, addr_prev;
  assign wpx       = (AW+1)'(wp_q);
  assign s1x       = (AW+1)'(stride);
  assign s2x       = (AW+1)'({stride, 1'b0});
  assign addr_cur  = (wpx >= s1x) ? wpx - s1x : wpx + (AW+1)'(DEPTH) - s1x;
  assign addr_prev = (wpx >= s2x) ? wpx - s2x : wpx + (AW+1)'(DEPTH) - s2x;

  logic [SW-1:0]        delay_store_q [DEPTH];
  logic signed [SW-1:0] rd_cur_q, rd_prev_q;

  always_ff @(posedge clk_i) begin
    if (advance) begin
      delay_store_q[wp_q] <= sample_i;
    end
    rd_cur_q  <= delay_store_q[addr_cur[AW-1:0]];
    rd_prev_q <= delay_store_q[addr_prev[AW-1:0]];
  end

  // stage 1: difference and magnitude
  logic                 s1_valid_q;
  afds_pkg::ctl_t       s1_ctl_q;
  logic signed [SW-1:0] s1_sample_q;
  logic signed [DW-1:0] nxt_ext, cur_ext, prv_ext, diff;
  logic [DW-1:0]        mag;
  logic                 neg;

  assign nxt_ext = DW'(s1_sample_q);
  assign cur_ext = DW'(rd_cur_q);
  assign prv_ext = DW'(rd_prev_q);
  assign diff    = (s1_ctl_q.mode == afds_pkg::MODE_CTR) ?
                   nxt_ext + prv_ext - (cur_ext <<< 1) : nxt_ext - cur_ext;
  assign neg     = diff[DW-1];
  assign mag     = neg ? DW'(-diff) : DW'(diff);

  // stage 2: partial products
  logic                 s2_valid_q;
  afds_pkg::ctl_t       s2_ctl_q;
  logic [DW-1:0]        s2_mag_q;
  logic                 s2_neg_q;

  // stage 3: sum, shift, saturate
  logic                         s3_valid_q;
  afds_pkg::ctl_t               s3_ctl_q;
  logic                         s3_neg_q;
  logic [afds_pkg::PP_W-1:0]    s3_pphi_q, s3_pplo_q;
  logic [afds_pkg::PROD_W-1:0]  prod, quo;
  logic                         sat;
  logic [SW-1:0]                val;

  assign prod = (afds_pkg::PROD_W'(s3_pphi_q) << afds_pkg::PP_SPLIT) +
                afds_pkg::PROD_W'(s3_pplo_q);
  assign quo  = prod >> FRAC_BITS;
  assign sat  = |quo[afds_pkg::PROD_W-1:SW-1];
  assign val  = s3_neg_q ? (sat ? afds_pkg::SAT_NEG : SW'(-quo[SW-1:0])) :
                           (sat ? afds_pkg::SAT_POS : quo[SW-1:0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= acc;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_ctl_q    <= ctl;
    s1_sample_q <= sample_i;
    s2_ctl_q    <= s1_ctl_q;
    s2_mag_q    <= mag;
    s2_neg_q    <= neg;
    s3_ctl_q    <= s2_ctl_q;
    s3_neg_q    <= s2_neg_q;
    s3_pphi_q   <= afds_pkg::PP_W'(s2_mag_q[DW-1:afds_pkg::PP_SPLIT]) *
                   afds_pkg::PP_W'(scale_q);
    s3_pplo_q   <= afds_pkg::PP_W'(s2_mag_q[afds_pkg::PP_SPLIT-1:0]) *
                   afds_pkg::PP_W'(scale_q);
  end

  // result queue with slot reservation at input acceptance
  afds_pkg::result_t oq_q [afds_pkg::OQ_DEPTH];
  afds_pkg::result_t e0, e1, head;
  logic [OQ_AW-1:0]  oq_wr_q, oq_rd_q;
  logic [RES_W-1:0]  oq_cnt_q, res_q;
  logic              w0, w1, out_fire;
  logic [1:0]        n_wr;

  assign w0       = s3_valid_q && s3_ctl_q.emit0;
  assign w1       = s3_valid_q && s3_ctl_q.emit1;
  assign n_wr     = {1'b0, w0} + {1'b0, w1};
  assign out_fire = out_valid_o && !out_stall_i;

  always_comb begin
    e0.idx   = s3_ctl_q.idx0;
    e0.value = s3_ctl_q.zero0 ? '0 : val;
    e0.err   = s3_ctl_q.err;
    e0.last  = s3_ctl_q.last0;
    e1.idx   = s3_ctl_q.idx1;
    e1.value = '0;
    e1.err   = 1'b0;
    e1.last  = 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (w0) begin
      oq_q[oq_wr_q] <= e0;
    end
    if (w1) begin
      oq_q[w0 ? oq_wr_q + OQ_AW'(1) : oq_wr_q] <= e1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oq_wr_q  <= '0;
      oq_rd_q  <= '0;
      oq_cnt_q <= '0;
      res_q    <= '0;
    end else begin
      oq_wr_q  <= oq_wr_q + OQ_AW'(n_wr);
      oq_rd_q  <= oq_rd_q + OQ_AW'(out_fire);
      oq_cnt_q <= oq_cnt_q + RES_W'(n_wr) - RES_W'(out_fire);
      res_q    <= res_q + RES_W'(acc ? n_res : 2'd0) - RES_W'(out_fire);
    end
  end

  assign in_stall_o    = res_q > RES_W'(afds_pkg::OQ_DEPTH - 2);
  assign head          = oq_q[oq_rd_q];
  assign out_valid_o   = oq_cnt_q != '0;
  assign point_index_o = head.idx;
  assign deriv_value_o = head.value;
  assign size_error_o  = head.err;
  assign last_of_run_o = head.last;

  `AFDS_ASSERT(a_res_bound, res_q <= RES_W'(afds_pkg::OQ_DEPTH), "result reservation overflow")
  `AFDS_ASSERT(a_queue_reserved, oq_cnt_q <= res_q, "queue holds unreserved results")
  `AFDS_ASSERT(a_s1_from_accept, s1_valid_q |-> $past(in_valid_i && !in_stall_o), "stage 1 without input transaction")

endmodule

[tb/sv/axis_finite_difference_stencil_unit_tb.sv]
`timescale 1ns / 100ps

module axis_finite_difference_stencil_unit_tb;
  import afds_pkg::*;

  localparam int unsigned STORE_DEPTH = 2 * MAX_PLANE_DEF;
  localparam int unsigned QUIET_LIMIT = 4000;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned LONG_HOLD = 100;
  localparam logic [AXIS_W-1:0] AXIS_BAD = 2'd3;

  typedef struct packed {
    logic [SAMPLE_W-1:0] value;
    logic                is_first;
  } sample_item_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic [SAMPLE_W-1:0] sample_i = '0;
  logic                first_i = 1'b0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [INDEX_W-1:0]  point_index_o;
  logic [SAMPLE_W-1:0] deriv_value_o;
  logic                size_error_o;
  logic                last_of_run_o;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [PADDR_W-1:0]  paddr = '0;
  logic [PDATA_W-1:0]  pwdata = '0;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  logic               cfg_mode = MODE_RST;
  logic [AXIS_W-1:0]  cfg_axis = AXIS_RST;
  logic [IXY_W-1:0]   cfg_ix = INT_XY_RST;
  logic [IXY_W-1:0]   cfg_iy = INT_XY_RST;
  logic [IZ_W-1:0]    cfg_iz = INT_Z_RST;
  logic [HALO_W-1:0]  cfg_halo = HALO_RST;
  logic [SCALE_W-1:0] cfg_scale = SCALE_RST;
  logic [BF_W-1:0]    cfg_bflags = BF_RST;

  logic [SAMPLE_W-1:0] plane_buf [STORE_DEPTH];
  int unsigned wr_ptr = 0;
  int unsigned px = 0, py = 0, pz = 0;

  sample_item_t sample_q [$];
  result_t      deriv_due_q [$];
  sample_item_t next_item;
  result_t      want_r;

  int unsigned gen_pos = 0;
  int unsigned n_queued = 0, n_in = 0, n_out = 0, n_cfg = 0, errs = 0;
  int unsigned tx_idle_pct = 0, rx_idle_pct = 0;
  int unsigned tx_gap = 0, rx_burst = 0, rx_hold = 0;
  int unsigned hold_req = 0, hold_seen = 0;
  int unsigned quiet_cycles = 0;
  logic [SAMPLE_W-1:0] corner_vals [12];

  axis_finite_difference_stencil_unit u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .sample_i      (sample_i),
    .first_i       (first_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .point_index_o (point_index_o),
    .deriv_value_o (deriv_value_o),
    .size_error_o  (size_error_o),
    .last_of_run_o (last_of_run_o),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [SAMPLE_W-1:0] scaled_sat(longint diff);
    logic [63:0] mag;
    logic [95:0] q;
    mag = (diff < 0) ? 64'(-diff) : 64'(diff);
    if (mag == 0 || cfg_scale == 0) return '0;
    q = ({32'b0, mag} * {64'b0, cfg_scale}) >> FRAC_BITS_DEF;
    if (diff < 0) begin
      if (q > 96'h8000_0000) q = 96'h8000_0000;
      return ~q[31:0] + 32'd1;
    end
    if (q > 96'h7FFF_FFFF) q = 96'h7FFF_FFFF;
    return q[31:0];
  endfunction

  function automatic longint plane_tap(int unsigned d);
    return longint'(signed'(plane_buf[(wr_ptr + STORE_DEPTH - d % STORE_DEPTH) % STORE_DEPTH]));
  endfunction

  function automatic void step_stencil(logic [SAMPLE_W-1:0] smp, logic is_first);
    int unsigned h, nx, ny, nz, stride, c, t, inner, lo, hi, pc;
    longint unsigned pt;
    longint nxt, cur, prv;
    logic bad;
    result_t r;
    h = cfg_halo;
    nx = cfg_ix + 2 * h;
    ny = cfg_iy + 2 * h;
    nz = cfg_iz + 2 * h;
    if (is_first) begin
      px = 0;
      py = 0;
      pz = 0;
    end
    bad = h > HALO_MAX || cfg_ix == 0 || cfg_iy == 0 || cfg_iz == 0 ||
          nx > MAX_LINE_DEF || ny > MAX_LINE_DEF || nx * ny > MAX_PLANE_DEF ||
          nz > MAX_LEVELS_DEF || cfg_axis > AXIS_Z;
    stride = 1;
    c = px;
    t = nx;
    inner = cfg_ix;
    if (cfg_axis == AXIS_Y) begin
      stride = nx;
      c = py;
      t = ny;
      inner = cfg_iy;
    end else if (cfg_axis == AXIS_Z) begin
      stride = nx * ny;
      c = pz;
      t = nz;
      inner = cfg_iz;
    end
    if (!bad && cfg_mode == MODE_CTR && inner < MIN_INNER) bad = 1'b1;
    r = '0;
    if (bad) begin
      r.err = 1'b1;
      r.last = 1'b1;
      deriv_due_q.push_back(r);
      return;
    end
    lo = h;
    hi = t - 1 - h;
    pt = (longint'(pz) * ny + py) * nx + px;
    nxt = longint'(signed'(smp));
    if (c >= 1) begin
      pc = c - 1;
      cur = plane_tap(stride);
      r.idx = INDEX_W'(pt - stride);
      if (cfg_mode == MODE_FWD) begin
        r.value = scaled_sat(nxt - cur);
        if (cfg_bflags[1] && pc == hi) r.value = '0;
      end else if (pc >= 1) begin
        prv = plane_tap(2 * stride);
        r.value = scaled_sat(nxt + prv - 2 * cur);
        if ((cfg_bflags[0] && pc == lo) || (cfg_bflags[1] && pc == hi)) r.value = '0;
      end
      r.last = (c != t - 1);
      deriv_due_q.push_back(r);
    end
    if (c == t - 1) begin
      r = '0;
      r.idx = INDEX_W'(pt);
      r.last = 1'b1;
      deriv_due_q.push_back(r);
    end
    plane_buf[wr_ptr] = smp;
    wr_ptr = (wr_ptr + 1) % STORE_DEPTH;
    px++;
    if (px >= nx) begin
      px = 0;
      py++;
      if (py >= ny) begin
        py = 0;
        pz++;
        if (pz >= nz) pz = 0;
      end
    end
  endfunction

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        step_stencil(sample_i, first_i);
        n_in++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (tx_gap > 0) begin
          tx_gap--;
          in_valid_i <= 1'b0;
        end else if (sample_q.size() > 0) begin
          next_item = sample_q.pop_front();
          sample_i <= next_item.value;
          first_i <= next_item.is_first;
          in_valid_i <= 1'b1;
          if ($urandom_range(99) < tx_idle_pct) tx_gap = $urandom_range(1, 4);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        n_out++;
        if (deriv_due_q.size() == 0) begin
          $error("unexpected result transaction: point_index %0d", point_index_o);
          errs++;
        end else begin
          want_r = deriv_due_q.pop_front();
          if (point_index_o !== want_r.idx) begin
            $error("point_index: expected %0d, got %0d", want_r.idx, point_index_o);
            errs++;
          end
          if (deriv_value_o !== want_r.value) begin
            $error("deriv_value: expected %h, got %h", want_r.value, deriv_value_o);
            errs++;
          end
          if (size_error_o !== want_r.err) begin
            $error("size_error: expected %b, got %b", want_r.err, size_error_o);
            errs++;
          end
          if (last_of_run_o !== want_r.last) begin
            $error("last_of_run: expected %b, got %b", want_r.last, last_of_run_o);
            errs++;
          end
        end
      end
      if (hold_seen != hold_req) begin
        hold_seen = hold_req;
        rx_hold = LONG_HOLD;
      end
      if (rx_hold > 0) begin
        rx_hold--;
        out_stall_i <= 1'b1;
      end else if (rx_burst > 0) begin
        rx_burst--;
        out_stall_i <= 1'b1;
      end else if ($urandom_range(99) < rx_idle_pct) begin
        rx_burst = $urandom_range(0, 3);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic logic [PDATA_W-1:0] reg_shadow(reg_idx_e r);
    case (r)
      REG_MODE:   return PDATA_W'(cfg_mode);
      REG_AXIS:   return PDATA_W'(cfg_axis);
      REG_INT_X:  return PDATA_W'(cfg_ix);
      REG_INT_Y:  return PDATA_W'(cfg_iy);
      REG_INT_Z:  return PDATA_W'(cfg_iz);
      REG_HALO:   return PDATA_W'(cfg_halo);
      REG_SCALE:  return cfg_scale;
      default:    return PDATA_W'(cfg_bflags);
    endcase
  endfunction

  task automatic apb_xfer(input logic wr, input reg_idx_e r, input logic [PDATA_W-1:0] wdata,
                          output logic [PDATA_W-1:0] rdata);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= {r, 2'b00};
    pwdata <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic cfg_write(reg_idx_e r, logic [PDATA_W-1:0] val);
    logic [PDATA_W-1:0] rd;
    apb_xfer(1'b1, r, val, rd);
    case (r)
      REG_MODE:   cfg_mode = val[0];
      REG_AXIS:   cfg_axis = val[AXIS_W-1:0];
      REG_INT_X:  cfg_ix = val[IXY_W-1:0];
      REG_INT_Y:  cfg_iy = val[IXY_W-1:0];
      REG_INT_Z:  cfg_iz = val[IZ_W-1:0];
      REG_HALO:   cfg_halo = val[HALO_W-1:0];
      REG_SCALE:  cfg_scale = val;
      default:    cfg_bflags = val[BF_W-1:0];
    endcase
    if (r != REG_SCALE && r != REG_BFLAGS) begin
      px = 0;
      py = 0;
      pz = 0;
    end
    n_cfg++;
    apb_xfer(1'b0, r, '0, rd);
    if (rd !== reg_shadow(r)) begin
      $error("register %s: expected %h, got %h", r.name(), reg_shadow(r), rd);
      errs++;
    end
  endtask

  task automatic set_geometry(logic md, logic [AXIS_W-1:0] ax, logic [IXY_W-1:0] ix,
                              logic [IXY_W-1:0] iy, logic [IZ_W-1:0] iz, logic [HALO_W-1:0] h);
    cfg_write(REG_MODE, PDATA_W'(md));
    cfg_write(REG_AXIS, PDATA_W'(ax));
    cfg_write(REG_INT_X, PDATA_W'(ix));
    cfg_write(REG_INT_Y, PDATA_W'(iy));
    cfg_write(REG_INT_Z, PDATA_W'(iz));
    cfg_write(REG_HALO, PDATA_W'(h));
    gen_pos = 0;
  endtask

  task automatic set_gain(logic [SCALE_W-1:0] s, logic [BF_W-1:0] bf);
    cfg_write(REG_SCALE, s);
    cfg_write(REG_BFLAGS, PDATA_W'(bf));
  endtask

  function automatic logic [SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(9))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2, 3:    return $urandom();
      default: return $urandom_range(0, 32'h0006_0000) - 32'h0003_0000;
    endcase
  endfunction

  function automatic logic [SCALE_W-1:0] rand_scale();
    case ($urandom_range(3))
      0:       return SCALE_RST;
      1:       return $urandom_range(32'h100, 32'h4_0000);
      2:       return $urandom();
      default: return $urandom_range(0, 3);
    endcase
  endfunction

  task automatic queue_items(int unsigned n);
    sample_item_t it;
    int unsigned vol;
    vol = (cfg_ix + 2 * cfg_halo) * (cfg_iy + 2 * cfg_halo) * (cfg_iz + 2 * cfg_halo);
    repeat (n) begin
      it.value = rand_sample();
      if (gen_pos == 0) begin
        it.is_first = 1'($urandom_range(0, 1));
      end else if ($urandom_range(99) < 3) begin
        it.is_first = 1'b1;
        gen_pos = 0;
      end else begin
        it.is_first = 1'b0;
      end
      sample_q.push_back(it);
      n_queued++;
      gen_pos = (gen_pos + 1) % vol;
    end
  endtask

  task automatic wait_drain();
    do @(negedge clk_i);
    while (sample_q.size() != 0 || in_valid_i || deriv_due_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic pick_random_config();
    logic md;
    logic [AXIS_W-1:0] ax;
    logic [IXY_W-1:0] ix, iy;
    logic [IZ_W-1:0] iz;
    logic [HALO_W-1:0] h;
    md = 1'($urandom_range(0, 1));
    ax = AXIS_W'($urandom_range(0, 2));
    ix = IXY_W'($urandom_range(1, 4));
    iy = IXY_W'($urandom_range(1, 4));
    iz = IZ_W'($urandom_range(1, 4));
    h = HALO_W'($urandom_range(0, 1));
    if (md == MODE_CTR && $urandom_range(9) != 0) begin
      case (ax)
        AXIS_X:  ix = IXY_W'($urandom_range(3, 6));
        AXIS_Y:  iy = IXY_W'($urandom_range(3, 6));
        default: iz = IZ_W'($urandom_range(3, 6));
      endcase
    end
    set_geometry(md, ax, ix, iy, iz, h);
    set_gain(rand_scale(), BF_W'($urandom_range(0, 3)));
  endtask

  initial begin
    sample_item_t it;
    int unsigned n;
    corner_vals = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000,
                    32'hFFFF_FFFF, 32'h0000_0001, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                    32'h0001_0000, 32'hFFFF_0000, 32'h8000_0000, 32'h5555_AAAA};
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset defaults, saturating differences on both rails
    for (int i = 0; i < 12; i++) begin
      it.value = corner_vals[i];
      it.is_first = (i == 0);
      sample_q.push_back(it);
      n_queued++;
    end
    wait_drain();

    // invalid sizes and an invalid axis
    set_geometry(MODE_FWD, AXIS_X, 7'd8, 7'd8, 11'd8, 3'd7);
    queue_items(2);
    wait_drain();
    set_geometry(MODE_FWD, AXIS_BAD, 7'd2, 7'd2, 11'd2, 3'd0);
    queue_items(2);
    wait_drain();
    set_geometry(MODE_FWD, AXIS_Y, 7'd0, 7'd3, 11'd3, 3'd1);
    queue_items(2);
    wait_drain();
    set_geometry(MODE_CTR, AXIS_X, 7'd127, 7'd64, 11'd3, 3'd1);
    queue_items(2);
    wait_drain();
    set_geometry(MODE_FWD, AXIS_Z, 7'd2, 7'd2, 11'd1023, 3'd1);
    queue_items(2);
    wait_drain();
    set_geometry(MODE_CTR, AXIS_Z, 7'd3, 7'd3, 11'd2, 3'd1);
    queue_items(2);
    wait_drain();

    tx_idle_pct = 20;
    rx_idle_pct = 20;
    set_geometry(MODE_CTR, AXIS_X, 7'd64, 7'd1, 11'd1, 3'd0);
    set_gain(32'hFFFF_FFFF, 2'b11);
    queue_items(64);
    wait_drain();

    set_geometry(MODE_FWD, AXIS_X, 7'd1, 7'd1, 11'd1, 3'd0);
    set_gain(32'h0, 2'b10);
    queue_items(8);
    wait_drain();

    set_geometry(MODE_FWD, AXIS_Z, 7'd1, 7'd1, 11'd1024, 3'd0);
    set_gain(SCALE_RST, 2'b01);
    queue_items(40);
    wait_drain();

    // hold the receiver off until the block fills and stalls its input
    tx_idle_pct = 0;
    set_geometry(MODE_CTR, AXIS_Z, 7'd2, 7'd2, 11'd3, 3'd1);
    set_gain(32'h0000_8000, 2'b01);
    hold_req++;
    queue_items(80);
    wait_drain();

    tx_idle_pct = 30;
    set_geometry(MODE_FWD, AXIS_Y, 7'd1, 7'd1, 11'd1, 3'd4);
    set_gain(32'h0002_0000, 2'b11);
    queue_items(40);
    wait_drain();

    while (n_queued < 460) begin
      tx_idle_pct = ($urandom_range(3) == 0) ? 0 : $urandom_range(5, 40);
      rx_idle_pct = ($urandom_range(3) == 0) ? 0 : $urandom_range(5, 40);
      pick_random_config();
      n = $urandom_range(30, 70);
      if ($urandom_range(2) == 0) begin
        queue_items(n / 2);
        wait_drain();
        set_gain(rand_scale(), BF_W'($urandom_range(0, 3)));
        queue_items(n - n / 2);
      end else begin
        queue_items(n);
      end
      wait_drain();
    end

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    pick_random_config();
    queue_items(40);
    wait_drain();

    $display("Checked %0d input and %0d result transactions over %0d register writes,",
             n_in, n_out, n_cfg);
    $display("with size errors, both modes, all axes, boundary zeroing and back-pressure.");
    if (errs == 0 && deriv_due_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
